FILE: sv/playfair_digraph_cipher_macros.svh
// Assertion macros used by the checker file of the digraph cipher.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define PDC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define PDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pdc_pkg.sv
package pdc_pkg;

    localparam int LETTER_W        = 5;
    localparam int SIDE            = 5;
    localparam int ROW_W           = SIDE * LETTER_W;
    localparam int POS_W           = 3;
    localparam int DATA_W          = 8;
    localparam int CFG_INDEX_W     = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_DECIPHER_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUARE_ROW_0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUARE_ROW_1  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUARE_ROW_2  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUARE_ROW_3  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUARE_ROW_4  = 3'd5;

    // Reset square: a..z without j, row-major.
    localparam logic [ROW_W-1:0] SQUARE_ROW_0_RST = 25'd4294688;
    localparam logic [ROW_W-1:0] SQUARE_ROW_1_RST = 25'd10755269;
    localparam logic [ROW_W-1:0] SQUARE_ROW_2_RST = 25'd16201099;
    localparam logic [ROW_W-1:0] SQUARE_ROW_3_RST = 25'd21613104;
    localparam logic [ROW_W-1:0] SQUARE_ROW_4_RST = 25'd27025109;

    typedef logic [LETTER_W-1:0]        letter_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [SIDE-1:0][ROW_W-1:0] square_t;

    typedef struct packed {
        pos_t row;
        pos_t col;
    } cell_pos_t;

    typedef enum logic [1:0] {
        JOB_PASS      = 2'd0,
        JOB_PAIR      = 2'd1,
        JOB_PAIR_PASS = 2'd2
    } job_kind_t;

    // One unit of work for the back end: a lone letter, a digraph, or a
    // digraph followed by a lone letter.
    typedef struct packed {
        job_kind_t kind;
        letter_t   first_letter;
        letter_t   second_letter;
        letter_t   pass_letter;
    } job_t;

    function automatic letter_t cell_at(square_t sq, pos_t row, pos_t col);
        return sq[row][LETTER_W*col +: LETTER_W];
    endfunction

    // First match in row-major order wins; j searches as i; no match gives 0,0.
    function automatic cell_pos_t locate(letter_t letter, square_t sq);
        letter_t   key;
        cell_pos_t pos;
        key = (letter == CODE_J) ? CODE_I : letter;
        pos = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r][LETTER_W*c +: LETTER_W] == key) begin
                    pos.row = POS_W'(r);
                    pos.col = POS_W'(c);
                end
            end
        end
        return pos;
    endfunction

    // One step around the square, forward or backward.
    function automatic pos_t step_pos(pos_t v, logic backward);
        pos_t res;
        if (backward) begin
            res = (v == '0) ? POS_W'(SIDE - 1) : v - 1'b1;
        end else begin
            res = (v == POS_W'(SIDE - 1)) ? '0 : v + 1'b1;
        end
        return res;
    endfunction

endpackage

FILE: sv/pdc_front.sv
module pdc_front import pdc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  letter_t in_letter,
    input  logic    in_last,
    output logic    in_ready,
    input  logic    q_full,
    output logic    push,
    output job_t    push_job
);

    letter_t pending_letter_reg, pending_letter_next;
    logic    pending_valid_reg, pending_valid_next;
    logic    accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb begin
        pending_letter_next    = pending_letter_reg;
        pending_valid_next     = pending_valid_reg;
        push                   = 1'b0;
        push_job               = '0;
        push_job.kind          = JOB_PASS;
        push_job.first_letter  = pending_letter_reg;
        push_job.second_letter = in_letter;
        push_job.pass_letter   = in_letter;
        if (accept) begin
            if (!pending_valid_reg) begin
                if (in_last) begin
                    push = 1'b1;
                end else begin
                    pending_letter_next = in_letter;
                    pending_valid_next  = 1'b1;
                end
            end else if (in_letter == pending_letter_reg) begin
                // A doubled letter is split by x and stays pending unless it ends the message.
                push                   = 1'b1;
                push_job.kind          = in_last ? JOB_PAIR_PASS : JOB_PAIR;
                push_job.second_letter = CODE_X;
                pending_valid_next     = !in_last;
            end else begin
                push               = 1'b1;
                push_job.kind      = JOB_PAIR;
                pending_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
        end else begin
            pending_letter_reg <= pending_letter_next;
            pending_valid_reg  <= pending_valid_next;
        end
    end

endmodule

FILE: sv/pdc_queue.sv
module pdc_queue import pdc_pkg::*; #(
    parameter int Depth = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    job_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/pdc_back.sv
module pdc_back import pdc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    decipher_mode,
    input  square_t square,
    input  logic    head_valid,
    input  job_t    head_job,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output letter_t out_letter,
    output logic    out_last
);

    job_t      job_reg, job_next;
    logic      loaded_reg, loaded_next;
    cell_pos_t pos_a_reg, pos_a_next;
    cell_pos_t pos_b_reg, pos_b_next;
    logic [1:0] idx_reg, idx_next;
    logic      out_valid_reg, out_valid_next;
    letter_t   out_letter_reg, out_letter_next;
    logic      out_last_reg, out_last_next;

    logic      fire, take, last_emit, same_row, same_col;
    logic [1:0] last_idx;
    pos_t      sel_row, sel_col;
    letter_t   emit_letter;

    assign fire = loaded_reg && (!out_valid_reg || out_ready);

    always_comb begin
        case (job_reg.kind)
            JOB_PASS:      last_idx = 2'd0;
            JOB_PAIR:      last_idx = 2'd1;
            JOB_PAIR_PASS: last_idx = 2'd2;
            default:       last_idx = 2'd0;
        endcase
    end

    assign last_emit = (idx_reg == last_idx);
    assign take      = !loaded_reg || (fire && last_emit);
    assign pop       = take && head_valid;

    // Cell chosen for the current output letter of a digraph.
    assign same_row = (pos_a_reg.row == pos_b_reg.row);
    assign same_col = (pos_a_reg.col == pos_b_reg.col);

    always_comb begin
        if (idx_reg == 2'd0) begin
            if (same_row) begin
                sel_row = pos_a_reg.row;
                sel_col = step_pos(pos_a_reg.col, decipher_mode);
            end else if (same_col) begin
                sel_row = step_pos(pos_a_reg.row, decipher_mode);
                sel_col = pos_a_reg.col;
            end else begin
                sel_row = pos_a_reg.row;
                sel_col = pos_b_reg.col;
            end
        end else begin
            if (same_row) begin
                sel_row = pos_a_reg.row;
                sel_col = step_pos(pos_b_reg.col, decipher_mode);
            end else if (same_col) begin
                sel_row = step_pos(pos_b_reg.row, decipher_mode);
                sel_col = pos_a_reg.col;
            end else begin
                sel_row = pos_b_reg.row;
                sel_col = pos_a_reg.col;
            end
        end
        if (job_reg.kind == JOB_PASS || idx_reg == 2'd2) begin
            emit_letter = job_reg.pass_letter;
        end else begin
            emit_letter = cell_at(square, sel_row, sel_col);
        end
    end

    always_comb begin
        job_next        = job_reg;
        loaded_next     = loaded_reg;
        pos_a_next      = pos_a_reg;
        pos_b_next      = pos_b_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_letter_next = out_letter_reg;
        out_last_next   = out_last_reg;

        if (fire) begin
            out_valid_next  = 1'b1;
            out_letter_next = emit_letter;
            out_last_next   = last_emit;
            idx_next        = idx_reg + 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (pop) begin
            job_next    = head_job;
            loaded_next = 1'b1;
            pos_a_next  = locate(head_job.first_letter, square);
            pos_b_next  = locate(head_job.second_letter, square);
            idx_next    = '0;
        end else if (take) begin
            loaded_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg        <= job_next;
        pos_a_reg      <= pos_a_next;
        pos_b_reg      <= pos_b_next;
        idx_reg        <= idx_next;
        out_letter_reg <= out_letter_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            loaded_reg    <= loaded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_letter = out_letter_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: sv/playfair_digraph_cipher.sv
// Playfair digraph cipher over a 5x5 key square. Letter codes (a=0 .. z=25)
// enter one per transaction on the s_ side, with s_tlast marking the last
// letter of a message, and are paired into digraphs: both letters are looked
// up in the key square (j takes the place of i), then a pair in one row moves
// one column right (encipher) or left (decipher), a pair in one column moves
// one row down or up, and any other pair swaps corners. A letter equal to the
// pending one is paired with x and stays pending unless it ends the message;
// a lone letter at the end of a message passes through unchanged. Each input
// transaction yields zero to three result transactions on the m_ side, and
// m_tlast flags the last result that one input caused. The front end takes
// one letter per cycle while its job queue has room; the back end drives one
// result per cycle from a single output register while m_tready is high, so
// a message streams at one letter per cycle, with one extra result for each
// doubled letter. A letter that completes a pair goes through the job queue
// and the back end's job register into the output register on the m_ side.
// The square and the mode are read live by the back end, so write them only
// while no letters are in flight; an index above five is ignored.
module playfair_digraph_cipher import pdc_pkg::*; #(
    parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Letter input channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,    // [4:0] letter, rest zero
    input  logic                   s_tlast,    // end_of_message
    // Result channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DATA_W-1:0]      m_tdata,    // [4:0] out_letter, rest zero
    output logic                   m_tlast,    // last_of_run
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]       cfg_wr_data
);

    // Configuration registers.
    logic    decipher_mode_reg, decipher_mode_next;
    square_t square_reg, square_next;

    always_comb begin
        decipher_mode_next = decipher_mode_reg;
        square_next        = square_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DECIPHER_MODE: decipher_mode_next = cfg_wr_data[0];
                CFG_SQUARE_ROW_0:  square_next[0]     = cfg_wr_data;
                CFG_SQUARE_ROW_1:  square_next[1]     = cfg_wr_data;
                CFG_SQUARE_ROW_2:  square_next[2]     = cfg_wr_data;
                CFG_SQUARE_ROW_3:  square_next[3]     = cfg_wr_data;
                CFG_SQUARE_ROW_4:  square_next[4]     = cfg_wr_data;
                default:           decipher_mode_next = decipher_mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decipher_mode_reg <= 1'b0;
            square_reg[0]     <= SQUARE_ROW_0_RST;
            square_reg[1]     <= SQUARE_ROW_1_RST;
            square_reg[2]     <= SQUARE_ROW_2_RST;
            square_reg[3]     <= SQUARE_ROW_3_RST;
            square_reg[4]     <= SQUARE_ROW_4_RST;
        end else begin
            decipher_mode_reg <= decipher_mode_next;
            square_reg        <= square_next;
        end
    end

    // The front end pairs letters and turns them into jobs for the queue.
    logic    q_full, q_push, q_pop, q_head_valid;
    job_t    q_push_job, q_head_job;
    letter_t out_letter;

    pdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_letter (s_tdata[LETTER_W-1:0]),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .q_full    (q_full),
        .push      (q_push),
        .push_job  (q_push_job)
    );

    // Short job queue so a stalled result port does not stop intake at once.
    pdc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // The back end locates the letters in the square and emits the results.
    pdc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .decipher_mode (decipher_mode_reg),
        .square        (square_reg),
        .head_valid    (q_head_valid),
        .head_job      (q_head_job),
        .pop           (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_letter    (out_letter),
        .out_last      (m_tlast)
    );

    assign m_tdata = {{(DATA_W - LETTER_W){1'b0}}, out_letter};

endmodule

FILE: sv/pdc_checker.sv
`include "playfair_digraph_cipher_macros.svh"

module pdc_checker import pdc_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast
);

    // After reset the result port is empty and intake is open.
    `PDC_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> !m_tvalid && s_tready, "bad state after reset")

    // A stalled result keeps its contents.
    `PDC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // The results of one input transaction follow each other without a gap.
    `PDC_ASSERT(a_run_gapless, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "gap inside a run of results")

    // Padding above the letter code stays zero.
    `PDC_ASSERT(a_out_pad, aclk, aresetn, m_tvalid |-> m_tdata[DATA_W-1:LETTER_W] == '0, "nonzero padding in result")

endmodule

bind playfair_digraph_cipher pdc_checker u_checker (.*);

FILE: test/tb_playfair_digraph_cipher.sv
`timescale 1ns / 1ps

// Self-checking testbench for the Playfair digraph cipher. Letters go in on the
// s_ stream, results come back on the m_ stream, and a scoreboard object keeps
// its own copy of the key square, the mode and the pending letter so that it
// can predict every result transaction from the letters that were accepted.
module tb_playfair_digraph_cipher;
    import pdc_pkg::*;

    // The two spare register indexes; writes to them must leave the block alone.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 3;
    // Room for a pair still in flight to leave the block before the registers change.
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PHASES    = 8;
    localparam int LETTERS_PER_PHASE = 50;
    localparam int REPORT_LIMIT     = 10;

    typedef enum int {
        SQ_RESET,
        SQ_SHUFFLED,
        SQ_RAW,
        SQ_ZERO,
        SQ_ONES
    } square_kind_t;

    // One predicted result transaction: the letter and its end-of-run flag.
    typedef struct packed {
        letter_t letter;
        logic    run_end;
    } cipher_out_t;

    // Scoreboard: mirrors the block's registers and pending letter, turns each
    // accepted letter into the result letters it should cause, and compares
    // the results that come out against them in order.
    class digraph_scoreboard;
        logic             decipher;
        logic [ROW_W-1:0] rows[SIDE];
        letter_t          held_letter;
        bit               held_valid;
        cipher_out_t      letters_due[$];
        int               mismatches;
        int               results_seen;

        function new();
            decipher     = 1'b0;
            rows[0]      = SQUARE_ROW_0_RST;
            rows[1]      = SQUARE_ROW_1_RST;
            rows[2]      = SQUARE_ROW_2_RST;
            rows[3]      = SQUARE_ROW_3_RST;
            rows[4]      = SQUARE_ROW_4_RST;
            held_letter  = '0;
            held_valid   = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [ROW_W-1:0] value);
            case (idx)
                CFG_DECIPHER_MODE: decipher = value[0];
                CFG_SQUARE_ROW_0:  rows[0] = value;
                CFG_SQUARE_ROW_1:  rows[1] = value;
                CFG_SQUARE_ROW_2:  rows[2] = value;
                CFG_SQUARE_ROW_3:  rows[3] = value;
                CFG_SQUARE_ROW_4:  rows[4] = value;
                default: ;
            endcase
        endfunction

        function letter_t square_letter(int r, int c);
            return rows[r][LETTER_W*c +: LETTER_W];
        endfunction

        // Row-major scan, first hit wins, j is looked up as i, a miss lands on 0,0.
        function void find_letter(letter_t l, output int r, output int c);
            letter_t key;
            bit      found;
            key   = (l == CODE_J) ? CODE_I : l;
            found = 1'b0;
            r     = 0;
            c     = 0;
            for (int rr = 0; rr < SIDE; rr++) begin
                for (int cc = 0; cc < SIDE; cc++) begin
                    if (!found && square_letter(rr, cc) == key) begin
                        r     = rr;
                        c     = cc;
                        found = 1'b1;
                    end
                end
            end
        endfunction

        function void push_letter(letter_t l);
            cipher_out_t item;
            item.letter  = l;
            item.run_end = 1'b0;
            letters_due.insert(letters_due.size(), item);
        endfunction

        function void transform_digraph(letter_t a, letter_t b);
            int r1, c1, r2, c2, shift;
            shift = decipher ? SIDE - 1 : 1;
            find_letter(a, r1, c1);
            find_letter(b, r2, c2);
            if (r1 == r2) begin
                push_letter(square_letter(r1, (c1 + shift) % SIDE));
                push_letter(square_letter(r1, (c2 + shift) % SIDE));
            end else if (c1 == c2) begin
                push_letter(square_letter((r1 + shift) % SIDE, c1));
                push_letter(square_letter((r2 + shift) % SIDE, c1));
            end else begin
                push_letter(square_letter(r1, c2));
                push_letter(square_letter(r2, c1));
            end
        endfunction

        function void note_letter(letter_t l, logic eom);
            int depth_at_entry;
            depth_at_entry = letters_due.size();
            if (!held_valid) begin
                if (eom) begin
                    push_letter(l);
                end else begin
                    held_letter = l;
                    held_valid  = 1'b1;
                end
            end else if (l == held_letter) begin
                transform_digraph(held_letter, CODE_X);
                if (eom) begin
                    push_letter(l);
                    held_valid = 1'b0;
                end
            end else begin
                transform_digraph(held_letter, l);
                held_valid = 1'b0;
            end
            if (letters_due.size() > depth_at_entry)
                letters_due[letters_due.size() - 1].run_end = 1'b1;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic run_end);
            cipher_out_t want;
            results_seen++;
            if (letters_due.size() == 0) begin
                flag($sformatf("unexpected result, data %0d last %0b", data, run_end));
                return;
            end
            want = letters_due.pop_front();
            if (data !== DATA_W'(want.letter) || run_end !== want.run_end)
                flag($sformatf("result %0d: expected data %0d last %0b, got data %0d last %0b",
                               results_seen, want.letter, want.run_end, data, run_end));
        endfunction

        function int outstanding();
            return letters_due.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;    // [4:0] letter, rest zero
    logic                   s_tlast;    // end_of_message
    logic                   m_tvalid;
    logic                   m_tready;
    logic [DATA_W-1:0]      m_tdata;    // [4:0] out_letter, rest zero
    logic                   m_tlast;    // last_of_run
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ROW_W-1:0]       cfg_wr_data;

    digraph_scoreboard sb = new();

    int sender_idle_pct;
    int ready_stall_pct;
    int letters_sent;
    int messages_sent;
    int key_settings;
    int quiet_cycles;

    playfair_digraph_cipher dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // The receiver picks its ready for the next edge at each falling edge, so
    // back-pressure lands on every phase of the output sequence.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Both channels are observed at the rising edge. An accepted letter is fed
    // to the predictor before a result of the same edge is checked; the block
    // cannot answer a letter in the cycle it takes it, so the order is safe.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_letter(s_tdata[LETTER_W-1:0], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
        end
    end

    // Watchdog: a long run of cycles in which neither channel moves a
    // transaction means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Every driving task is entered and left at a falling edge.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ROW_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        sb.set_register(idx, value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Offers one letter, idling first at the current sender rate, and holds
    // tvalid high until the block takes it.
    task automatic send_letter(letter_t letter, logic eom);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(letter);
        s_tlast  <= eom;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        letters_sent++;
    endtask

    // A message of random letters; about one letter in four repeats the one
    // before it so that doubled letters and the x filler show up often.
    task automatic send_message(int len);
        letter_t letter;
        letter_t prior;
        prior = '0;
        for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(3) == 0)
                letter = prior;
            else
                letter = letter_t'($urandom_range(25));
            send_letter(letter, k == len - 1);
            prior = letter;
        end
        messages_sent++;
    endtask

    // Lets every predicted result come out, then waits out the settling time so
    // that a pair still in flight is finished before the registers change.
    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_square(square_kind_t kind);
        logic [ROW_W-1:0] rows[SIDE];
        letter_t          codes[SIDE*SIDE];
        letter_t          swap;
        int               n;
        int               pick;
        case (kind)
            SQ_RESET: begin
                rows[0] = SQUARE_ROW_0_RST;
                rows[1] = SQUARE_ROW_1_RST;
                rows[2] = SQUARE_ROW_2_RST;
                rows[3] = SQUARE_ROW_3_RST;
                rows[4] = SQUARE_ROW_4_RST;
            end
            SQ_SHUFFLED: begin
                // A proper key square: the 25 letters without j in random order.
                n = 0;
                for (int code = 0; code < 26; code++) begin
                    if (letter_t'(code) != CODE_J) begin
                        codes[n] = letter_t'(code);
                        n++;
                    end
                end
                for (int k = SIDE*SIDE - 1; k > 0; k--) begin
                    pick        = $urandom_range(k);
                    swap        = codes[k];
                    codes[k]    = codes[pick];
                    codes[pick] = swap;
                end
                for (int r = 0; r < SIDE; r++)
                    for (int c = 0; c < SIDE; c++)
                        rows[r][LETTER_W*c +: LETTER_W] = codes[r*SIDE + c];
            end
            SQ_RAW: begin
                // Arbitrary bits: duplicates, missing letters and cells above z.
                for (int r = 0; r < SIDE; r++)
                    rows[r] = ROW_W'($urandom());
            end
            SQ_ZERO: begin
                for (int r = 0; r < SIDE; r++)
                    rows[r] = '0;
            end
            default: begin
                for (int r = 0; r < SIDE; r++)
                    rows[r] = '1;
            end
        endcase
        write_reg(CFG_SQUARE_ROW_0, rows[0]);
        write_reg(CFG_SQUARE_ROW_1, rows[1]);
        write_reg(CFG_SQUARE_ROW_2, rows[2]);
        write_reg(CFG_SQUARE_ROW_3, rows[3]);
        write_reg(CFG_SQUARE_ROW_4, rows[4]);
    endtask

    // Hand-picked letters for the default square (rows abcde, fghik, lmnop,
    // qrstu, vwxyz): a lone final letter, pairs in one row and in one column
    // with wrap-around, a corner swap, i with j sharing a cell, repeated x,
    // a doubled letter inside a message and at its end, and codes up to z.
    task automatic run_directed();
        letter_t pick_letters[$];
        logic    pick_ends[$];
        pick_letters = '{0, 0, 4, 4, 0, 0, 21, 21, 0, 0, 25, CODE_I, CODE_J,
                         CODE_X, CODE_X, CODE_X, 3, 3, 7, 11, 11, CODE_J, 25, 16};
        pick_ends    = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                         0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 1};
        for (int k = 0; k < pick_letters.size(); k++)
            send_letter(pick_letters[k], pick_ends[k]);
        messages_sent += 5;
    endtask

    initial begin
        int           start_count;
        square_kind_t kind;

        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wr_data     = '0;
        sender_idle_pct = 0;
        ready_stall_pct = 0;
        letters_sent    = 0;
        messages_sent   = 0;
        key_settings    = 0;
        quiet_cycles    = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed letters, first on the reset registers, then deciphering.
        run_directed();
        key_settings++;
        drain();
        write_reg(CFG_DECIPHER_MODE, ROW_W'(1));
        run_directed();
        key_settings++;

        // Random messages under a new key and idling pattern in each phase.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph)
                2:       kind = SQ_ONES;
                3:       kind = SQ_ZERO;
                4, 6:    kind = SQ_RAW;
                7:       kind = SQ_RESET;
                default: kind = SQ_SHUFFLED;
            endcase
            write_reg(CFG_DECIPHER_MODE, ROW_W'(ph % 2));
            load_square(kind);
            if (ph == 1 || ph == 5) begin
                // These land on no register; the key must stay as it is.
                write_reg(CFG_SPARE_6, ROW_W'($urandom()));
                write_reg(CFG_SPARE_7, '1);
            end
            case (ph % 4)
                0:       begin sender_idle_pct = 0;  ready_stall_pct = 0;  end
                1:       begin sender_idle_pct = 45; ready_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  ready_stall_pct = 45; end
                default: begin sender_idle_pct = 35; ready_stall_pct = 35; end
            endcase
            key_settings++;
            start_count = letters_sent;
            while (letters_sent - start_count < LETTERS_PER_PHASE)
                send_message($urandom_range(1, 9));
        end

        drain();
        $display("Sent %0d letters in %0d messages under %0d key and mode settings;",
                 letters_sent, messages_sent, key_settings);
        $display("checked %0d result letters against the prediction.", sb.results_seen);
        if (sb.outstanding() != 0)
            $display("%0d predicted results never came out", sb.outstanding());
        if (sb.mismatches > 0)
            $display("%0d mismatching results in total", sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/pdc_pkg.sv
sv/pdc_front.sv
sv/pdc_queue.sv
sv/pdc_back.sv
sv/playfair_digraph_cipher.sv
sv/pdc_checker.sv
test/tb_playfair_digraph_cipher.sv
